// ----- sv/sat_pkg.sv -----
// Shared types, constants and command/status structs of the sorted address table.
// Used by every other file of the block; depends on nothing.
package sat_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int OWNER_BITS     = 8;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int COUNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W          = 32;
  localparam int CMD_W          = 2;
  localparam int SERVER_W       = 8;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic start;
    logic probe;
    logic step;
    logic latch_result;
    logic shift_read;
    logic shift_write;
    logic finish_shift;
    logic load_out;
  } sat_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic key_eq;
    logic shift_up;
    logic shift_down;
    logic shift_more;
  } sat_stat_t;

endpackage

// ----- sv/sat_ifs.sv -----
// Request and response channel interfaces of the sorted address table.
// Depends on sat_pkg for field widths.
interface sat_req_if;
  logic                         valid;
  logic                         ready;
  logic [sat_pkg::CMD_W-1:0]    cmd;
  logic [sat_pkg::KEY_W-1:0]    host_address;
  logic [sat_pkg::SERVER_W-1:0] server_id;

  modport source (output valid, output cmd, output host_address, output server_id,
                  input ready);
  modport sink   (input valid, input cmd, input host_address, input server_id,
                  output ready);
endinterface

interface sat_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [sat_pkg::SERVER_W-1:0]      owner_id;
  logic [sat_pkg::STATUS_W-1:0]      status;
  logic [sat_pkg::ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output found, output owner_id, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input owner_id, input status,
                  input entry_count, output ready);
endinterface

// ----- sv/sat_datapath.sv -----
// Datapath of the sorted address table: entry memory, search bounds, shift index,
// result and output registers. Driven by sat_ctrl commands; depends on sat_pkg.
module sat_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sat_pkg::sat_cmd_t                 cmd,
  output sat_pkg::sat_stat_t                stat,
  input  logic [sat_pkg::CMD_W-1:0]         req_cmd,
  input  logic [sat_pkg::KEY_W-1:0]         req_key,
  input  logic [sat_pkg::SERVER_W-1:0]      req_server,
  output logic                              found,
  output logic [sat_pkg::SERVER_W-1:0]      owner_id,
  output logic [sat_pkg::STATUS_W-1:0]      status,
  output logic [sat_pkg::ENTRY_COUNT_W-1:0] entry_count
);

  sat_pkg::entry_t mem [sat_pkg::TABLE_DEPTH];
  sat_pkg::entry_t rd_data;

  logic [sat_pkg::CMD_W-1:0]      op;
  logic [sat_pkg::KEY_W-1:0]      key;
  logic [sat_pkg::OWNER_BITS-1:0] owner_in;
  logic [sat_pkg::COUNT_W-1:0]    used;
  logic [sat_pkg::COUNT_W-1:0]    lo;
  logic [sat_pkg::COUNT_W-1:0]    hi;
  logic [sat_pkg::COUNT_W-1:0]    pos;
  logic [sat_pkg::COUNT_W-1:0]    idx;
  logic                           hit;
  logic [sat_pkg::OWNER_BITS-1:0] match_owner;
  logic                           res_found;
  logic [sat_pkg::OWNER_BITS-1:0] res_owner;
  logic [sat_pkg::STATUS_W-1:0]   res_status;

  logic [sat_pkg::COUNT_W-1:0]    mid;
  logic [sat_pkg::COUNT_W:0]      idx_inc;
  logic [sat_pkg::COUNT_W-1:0]    rd_ptr;
  logic [sat_pkg::ADDR_W-1:0]     rd_addr;
  logic                           rd_en;
  logic [sat_pkg::ADDR_W-1:0]     wr_addr;
  logic                           wr_en;
  sat_pkg::entry_t                wr_data;
  logic                           is_insert;
  logic                           is_remove;
  logic                           full;

  assign is_insert = (op == sat_pkg::CMD_INSERT);
  assign is_remove = (op == sat_pkg::CMD_REMOVE);
  assign full      = (used == sat_pkg::COUNT_W'(sat_pkg::TABLE_DEPTH));
  assign mid       = lo + ((hi - lo) >> 1);
  assign idx_inc   = {1'b0, idx} + 1'b1;

  assign stat.lo_lt_hi   = (lo < hi);
  assign stat.key_eq     = (rd_data.key == key);
  assign stat.shift_up   = is_insert && !hit && !full;
  assign stat.shift_down = is_remove && hit;
  assign stat.shift_more = is_insert ? (idx > pos) : (idx_inc < {1'b0, used});

  always_comb begin
    rd_en  = cmd.probe || cmd.shift_read;
    rd_ptr = mid;
    if (cmd.shift_read) begin
      rd_ptr = is_insert ? (idx - 1'b1) : idx_inc[sat_pkg::COUNT_W-1:0];
    end
    rd_addr = rd_ptr[sat_pkg::ADDR_W-1:0];

    wr_en   = cmd.shift_write || (cmd.finish_shift && is_insert);
    wr_addr = idx[sat_pkg::ADDR_W-1:0];
    wr_data = rd_data;
    if (cmd.finish_shift) begin
      wr_addr = pos[sat_pkg::ADDR_W-1:0];
      wr_data = '{key: key, owner: owner_in};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.finish_shift) begin
      used <= is_insert ? (used + 1'b1) : (used - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op       <= req_cmd;
      key      <= req_key;
      owner_in <= sat_pkg::OWNER_BITS'(req_server);
      lo       <= '0;
      hi       <= used;
      hit      <= 1'b0;
    end
    if (cmd.probe) begin
      pos <= stat.lo_lt_hi ? mid : lo;
    end
    if (cmd.step) begin
      if (stat.key_eq) begin
        hit         <= 1'b1;
        match_owner <= rd_data.owner;
      end else if (rd_data.key < key) begin
        lo <= pos + 1'b1;
      end else begin
        hi <= pos;
      end
    end
    if (cmd.latch_result) begin
      res_found <= hit;
      res_owner <= hit ? match_owner : '0;
      if (is_insert) begin
        res_status <= hit ? sat_pkg::STAT_DUPLICATE :
                      (full ? sat_pkg::STAT_FULL : sat_pkg::STAT_DONE);
      end else begin
        res_status <= hit ? sat_pkg::STAT_DONE : sat_pkg::STAT_NOT_FOUND;
      end
      idx <= is_insert ? used : pos;
    end
    if (cmd.shift_write) begin
      idx <= is_insert ? (idx - 1'b1) : idx_inc[sat_pkg::COUNT_W-1:0];
    end
    if (cmd.load_out) begin
      found       <= res_found;
      owner_id    <= sat_pkg::SERVER_W'(res_owner);
      status      <= res_status;
      entry_count <= sat_pkg::ENTRY_COUNT_W'(used);
    end
  end

endmodule

// ----- sv/sat_ctrl.sv -----
// Controller of the sorted address table: sequences search, shift and response.
// Issues sat_cmd_t to sat_datapath and reads sat_stat_t; depends on sat_pkg.
module sat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sat_pkg::sat_cmd_t  cmd,
  input  sat_pkg::sat_stat_t stat
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_COMPARE  = 3'd2;
  localparam logic [2:0] S_EXEC     = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.probe  = 1'b1;
        state_next = stat.lo_lt_hi ? S_COMPARE : S_EXEC;
      end
      S_COMPARE: begin
        cmd.step   = 1'b1;
        state_next = stat.key_eq ? S_EXEC : S_SEARCH;
      end
      S_EXEC: begin
        cmd.latch_result = 1'b1;
        state_next = (stat.shift_up || stat.shift_down) ? S_SHIFT_RD : S_FINISH;
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.shift_read = 1'b1;
          state_next     = S_SHIFT_WR;
        end else begin
          cmd.finish_shift = 1'b1;
          state_next       = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
        state_next      = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/sorted_address_table.sv -----
// Sorted address table: up to 64 IPv4 keys in ascending order, each with an owner id.
// Top level; joins sat_ctrl and sat_datapath to the request and response channels.
//
// Usage:
//   req carries one request: cmd (lookup, insert, remove; code 3 acts as lookup),
//   host_address and server_id. rsp returns exactly one response per request:
//   found, owner_id, status and entry_count after the operation.
//   Requests are taken one at a time; req.ready is high only while the block is idle.
//   Each binary-search probe reads the entry memory once; an insert or remove that
//   changes the table also moves entries (at most 63), each with one read and one
//   write; an insert then writes the new entry before the response is loaded.
//   With rsp not stalled, the next request can be accepted in the cycle after the load.
//   The response sits in an output register, so the next request is accepted
//   while it waits; a stalled rsp holds the block only when the next response is
//   ready to load.
//   Reset (rst, synchronous) empties the table and drops any pending response.
//   No clearing pass is needed: data read beyond the count is never used.
module sorted_address_table (
  input logic      clk,
  input logic      rst,
  sat_req_if.sink   req,
  sat_rsp_if.source rsp
);

  sat_pkg::sat_cmd_t  cmd;
  sat_pkg::sat_stat_t stat;

  sat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sat_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_cmd     (req.cmd),
    .req_key     (req.host_address),
    .req_server  (req.server_id),
    .found       (rsp.found),
    .owner_id    (rsp.owner_id),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench of sorted_address_table: directed, fill-to-full and random request streams.
// A mirror of the sorted table predicts every response, and each response is checked in order.
// Depends on sat_pkg, sat_ifs and the sorted_address_table RTL.
module tb_top;

  localparam logic [sat_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic                              found;
    logic [sat_pkg::SERVER_W-1:0]      owner_id;
    logic [sat_pkg::STATUS_W-1:0]      status;
    logic [sat_pkg::ENTRY_COUNT_W-1:0] entry_count;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sat_req_if req_ch ();
  sat_rsp_if rsp_ch ();

  sorted_address_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic [sat_pkg::KEY_W-1:0]      mirror_keys   [sat_pkg::TABLE_DEPTH];
  logic [sat_pkg::OWNER_BITS-1:0] mirror_owners [sat_pkg::TABLE_DEPTH];
  int                             mirror_count  = 0;
  table_reply_t                   pending_replies [$];
  int                             error_count   = 0;
  int                             send_idle_pct = 0;
  int                             recv_idle_pct = 0;
  bit                             growing       = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.cmd          = sat_pkg::CMD_LOOKUP;
    req_ch.host_address = '0;
    req_ch.server_id    = '0;
    rsp_ch.ready        = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic table_reply_t apply_table_op(
      input logic [sat_pkg::CMD_W-1:0]    op,
      input logic [sat_pkg::KEY_W-1:0]    addr,
      input logic [sat_pkg::SERVER_W-1:0] server);
    table_reply_t r;
    int lo;
    int hi;
    int mid;
    int pos;
    bit hit;
    lo  = 0;
    hi  = mirror_count;
    hit = 1'b0;
    pos = 0;
    r   = '0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (mirror_keys[mid] == addr) begin
        hit = 1'b1;
        pos = mid;
      end else if (mirror_keys[mid] < addr) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (!hit) pos = lo;
    case (op)
      sat_pkg::CMD_INSERT: begin
        if (hit) begin
          r.found    = 1'b1;
          r.owner_id = mirror_owners[pos];
          r.status   = sat_pkg::STAT_DUPLICATE;
        end else if (mirror_count >= sat_pkg::TABLE_DEPTH) begin
          r.status = sat_pkg::STAT_FULL;
        end else begin
          for (int i = mirror_count; i > pos; i--) begin
            mirror_keys[i]   = mirror_keys[i-1];
            mirror_owners[i] = mirror_owners[i-1];
          end
          mirror_keys[pos]   = addr;
          mirror_owners[pos] = server[sat_pkg::OWNER_BITS-1:0];
          mirror_count++;
          r.status = sat_pkg::STAT_DONE;
        end
      end
      sat_pkg::CMD_REMOVE: begin
        if (hit) begin
          r.found    = 1'b1;
          r.owner_id = mirror_owners[pos];
          for (int i = pos; i + 1 < mirror_count; i++) begin
            mirror_keys[i]   = mirror_keys[i+1];
            mirror_owners[i] = mirror_owners[i+1];
          end
          mirror_count--;
          r.status = sat_pkg::STAT_DONE;
        end else begin
          r.status = sat_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        if (hit) begin
          r.found    = 1'b1;
          r.owner_id = mirror_owners[pos];
          r.status   = sat_pkg::STAT_DONE;
        end else begin
          r.status = sat_pkg::STAT_NOT_FOUND;
        end
      end
    endcase
    r.entry_count = mirror_count[sat_pkg::ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  // Call at a falling edge; returns at a falling edge.
  task automatic send_request(input logic [sat_pkg::CMD_W-1:0]    op,
                              input logic [sat_pkg::KEY_W-1:0]    addr,
                              input logic [sat_pkg::SERVER_W-1:0] server);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    req_ch.valid        = 1'b1;
    req_ch.cmd          = op;
    req_ch.host_address = addr;
    req_ch.server_id    = server;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_replies.push_back(apply_table_op(op, addr, server));
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        want = pending_replies.pop_front();
        if (rsp_ch.found !== want.found)
          report_mismatch($sformatf("found: want %0d got %0d", want.found, rsp_ch.found));
        if (rsp_ch.owner_id !== want.owner_id)
          report_mismatch($sformatf("owner_id: want %0d got %0d",
                                    want.owner_id, rsp_ch.owner_id));
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status: want %0d got %0d", want.status, rsp_ch.status));
        if (rsp_ch.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count: want %0d got %0d",
                                    want.entry_count, rsp_ch.entry_count));
      end
    end
  end

  task automatic test_directed_cases();
    send_request(sat_pkg::CMD_LOOKUP, 32'h0000_0000, 8'h00);
    send_request(sat_pkg::CMD_REMOVE, 32'h1234_5678, 8'h11);
    send_request(CMD_SPARE,           32'hFFFF_FFFF, 8'hFF);
    send_request(sat_pkg::CMD_INSERT, 32'h8000_0000, 8'h5A);
    send_request(sat_pkg::CMD_INSERT, 32'h0000_0000, 8'h00);
    send_request(sat_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_request(sat_pkg::CMD_INSERT, 32'h7FFF_FFFF, 8'hA5);
    send_request(sat_pkg::CMD_INSERT, 32'h8000_0001, 8'h01);
    send_request(sat_pkg::CMD_INSERT, 32'h8000_0000, 8'h33);
    send_request(sat_pkg::CMD_LOOKUP, 32'h0000_0000, 8'h00);
    send_request(sat_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    send_request(sat_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 8'hFF);
    send_request(sat_pkg::CMD_LOOKUP, 32'h8000_0002, 8'h00);
    send_request(CMD_SPARE,           32'h8000_0000, 8'h00);
    send_request(sat_pkg::CMD_REMOVE, 32'h8000_0000, 8'h00);
    send_request(sat_pkg::CMD_REMOVE, 32'h8000_0000, 8'h00);
    send_request(sat_pkg::CMD_REMOVE, 32'h0000_0000, 8'hFF);
    send_request(sat_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 8'h00);
    send_request(sat_pkg::CMD_LOOKUP, 32'h8000_0001, 8'h00);
    send_request(sat_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 8'h00);
    send_request(sat_pkg::CMD_REMOVE, 32'h8000_0001, 8'h00);
    send_request(sat_pkg::CMD_LOOKUP, 32'h8000_0001, 8'h00);
  endtask

  task automatic test_full_table();
    while (mirror_count < sat_pkg::TABLE_DEPTH)
      send_request(sat_pkg::CMD_INSERT, $urandom, 8'($urandom_range(255)));
    send_request(sat_pkg::CMD_INSERT, $urandom, 8'($urandom_range(255)));
    send_request(sat_pkg::CMD_INSERT, mirror_keys[0], 8'($urandom_range(255)));
    send_request(sat_pkg::CMD_INSERT, mirror_keys[sat_pkg::TABLE_DEPTH-1],
                 8'($urandom_range(255)));
    send_request(sat_pkg::CMD_LOOKUP, mirror_keys[0], 8'h00);
    send_request(CMD_SPARE, mirror_keys[sat_pkg::TABLE_DEPTH-1], 8'h00);
    while (mirror_count > 0) begin
      if ($urandom_range(7) == 0)
        send_request(sat_pkg::CMD_REMOVE, $urandom, 8'($urandom_range(255)));
      send_request(sat_pkg::CMD_REMOVE, mirror_keys[$urandom_range(mirror_count - 1)],
                   8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_mix(input int n_items, input int send_pct, input int recv_pct);
    logic [sat_pkg::CMD_W-1:0] op;
    logic [sat_pkg::KEY_W-1:0] addr;
    int                        pick;
    int                        idx;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) begin
      if (mirror_count >= sat_pkg::TABLE_DEPTH) growing = 1'b0;
      else if (mirror_count == 0) growing = 1'b1;
      pick = $urandom_range(99);
      if (pick < 5) op = CMD_SPARE;
      else if (pick < 25) op = sat_pkg::CMD_LOOKUP;
      else if (pick < (growing ? 80 : 45)) op = sat_pkg::CMD_INSERT;
      else op = sat_pkg::CMD_REMOVE;
      pick = $urandom_range(99);
      idx  = (mirror_count > 0) ? $urandom_range(mirror_count - 1) : 0;
      if (mirror_count > 0 && pick < 55) addr = mirror_keys[idx];
      else if (mirror_count > 0 && pick < 70)
        addr = pick[0] ? mirror_keys[idx] + 32'd1 : mirror_keys[idx] - 32'd1;
      else if (pick < 74) addr = pick[0] ? '1 : '0;
      else addr = $urandom;
      send_request(op, addr, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 57;
    test_directed_cases();
    test_full_table();
    test_random_mix(250, 9, 57);
    test_random_mix(250, 57, 9);
    test_random_mix(250, 0, 0);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
